FILE: design/jsu_pkg.sv
// Shared types, codes and helper functions of the JSON string unescape block.
`timescale 1ns / 1ps
`default_nettype none

package jsu_pkg;

  // Result kind, carried on the output tuser.
  typedef enum logic [1:0] {
    KIND_DATA = 2'd0,
    KIND_DONE = 2'd1,
    KIND_ERR  = 2'd2
  } kind_e;

  // Error numbers carried with an error result.
  typedef enum logic [2:0] {
    ERR_UNTERM_STR = 3'd0,
    ERR_CTRL_CHAR  = 3'd1,
    ERR_UNTERM_ESC = 3'd2,
    ERR_TRUNC_U    = 3'd3,
    ERR_BAD_HEX    = 3'd4,
    ERR_UNKNOWN    = 3'd5
  } err_e;

  // Decoder modes, one-hot.
  typedef enum logic [5:0] {
    MODE_NORMAL     = 6'b000001,
    MODE_ESC        = 6'b000010,
    MODE_HEX        = 6'b000100,
    MODE_AFTER_HI   = 6'b001000,
    MODE_AFTER_HI_BS = 6'b010000,
    MODE_LOW_HEX    = 6'b100000
  } mode_e;

  localparam logic [7:0] ChQuote     = 8'h22;
  localparam logic [7:0] ChBackslash = 8'h5C;
  localparam logic [7:0] ChU         = 8'h75;
  localparam logic [7:0] ChSpace     = 8'h20;

  // UTF-8 bytes of U+FFFD.
  localparam logic [2:0][7:0] FffdBytes = {8'hBD, 8'hBF, 8'hEF};

  // UTF-8 encoding of one code point: byte count and bytes, first in [0].
  typedef struct packed {
    logic [2:0]      nb;
    logic [3:0][7:0] bytes;
  } utf8_t;

  // Work handed from the front end to the back end for one request:
  // an optional U+FFFD, then nb encoded bytes, then an optional terminal result.
  typedef struct packed {
    logic            fffd;
    logic [2:0]      nb;
    logic [3:0][7:0] bytes;
    logic            term_en;
    logic            term_err;
    err_e            err;
  } cmd_t;

  typedef struct packed {
    logic valid;
    logic full;
  } q_stat_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] value;
  } esc_t;

  function automatic utf8_t utf8_encode(input logic [20:0] cp);
    utf8_t r;
    r = '0;
    if (cp < 21'h80) begin
      r.nb = 3'd1;
      r.bytes[0] = cp[7:0];
    end else if (cp < 21'h800) begin
      r.nb = 3'd2;
      r.bytes[0] = {3'b110, cp[10:6]};
      r.bytes[1] = {2'b10, cp[5:0]};
    end else if (cp < 21'h10000) begin
      r.nb = 3'd3;
      r.bytes[0] = {4'b1110, cp[15:12]};
      r.bytes[1] = {2'b10, cp[11:6]};
      r.bytes[2] = {2'b10, cp[5:0]};
    end else begin
      r.nb = 3'd4;
      r.bytes[0] = {5'b11110, cp[20:18]};
      r.bytes[1] = {2'b10, cp[17:12]};
      r.bytes[2] = {2'b10, cp[11:6]};
      r.bytes[3] = {2'b10, cp[5:0]};
    end
    return r;
  endfunction

  function automatic logic is_hex(input logic [7:0] c);
    return ((c >= 8'h30) && (c <= 8'h39)) || ((c >= 8'h61) && (c <= 8'h66)) ||
           ((c >= 8'h41) && (c <= 8'h46));
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [7:0] v;
    if (c <= 8'h39) begin
      v = c - 8'h30;
    end else if (c >= 8'h61) begin
      v = c - 8'h57;
    end else begin
      v = c - 8'h37;
    end
    return v[3:0];
  endfunction

  // Simple escapes; the \u escape is handled by the caller.
  function automatic esc_t esc_map(input logic [7:0] c);
    esc_t r;
    r.valid = 1'b1;
    case (c)
      8'h22:   r.value = 8'h22;
      8'h5C:   r.value = 8'h5C;
      8'h2F:   r.value = 8'h2F;
      8'h62:   r.value = 8'h08;
      8'h66:   r.value = 8'h0C;
      8'h6E:   r.value = 8'h0A;
      8'h72:   r.value = 8'h0D;
      8'h74:   r.value = 8'h09;
      default: begin
        r.valid = 1'b0;
        r.value = 8'h00;
      end
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: design/jsu_front.sv
// Front end: tracks the escape state and turns each request into a result command.
`timescale 1ns / 1ps
`default_nettype none

module jsu_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          accept_i,
  input  wire logic [7:0]    byte_i,
  input  wire logic          end_i,
  output jsu_pkg::cmd_t      cmd_o,
  output logic               cmd_valid_o
);

  jsu_pkg::mode_e mode_q, mode_d;
  logic [1:0]     cnt_q, cnt_d;
  logic [15:0]    acc_q, acc_d;
  logic [9:0]     pend_q, pend_d;

  jsu_pkg::cmd_t  cmd;
  jsu_pkg::utf8_t enc;
  jsu_pkg::esc_t  esc;
  logic [15:0]    acc_n;
  logic [20:0]    pair_cp;
  logic           body_en;
  logic           esc_en;
  logic           uni_en;

  assign acc_n   = {acc_q[11:0], jsu_pkg::hex_val(byte_i)};
  // Both halves carry ten payload bits; the pair sits above the basic plane.
  assign pair_cp = 21'h10000 + {1'b0, pend_q, acc_n[9:0]};
  assign esc     = jsu_pkg::esc_map(byte_i);

  always_comb begin
    cmd     = '0;
    cmd.err = jsu_pkg::ERR_UNTERM_STR;
    mode_d  = mode_q;
    cnt_d   = cnt_q;
    acc_d   = acc_q;
    pend_d  = pend_q;
    body_en = 1'b0;
    esc_en  = 1'b0;
    uni_en  = 1'b0;
    enc     = '0;

    if (end_i) begin
      cmd.term_en  = 1'b1;
      cmd.term_err = 1'b1;
      mode_d       = jsu_pkg::MODE_NORMAL;
      case (mode_q)
        jsu_pkg::MODE_ESC:     cmd.err = jsu_pkg::ERR_UNTERM_ESC;
        jsu_pkg::MODE_HEX,
        jsu_pkg::MODE_LOW_HEX: cmd.err = jsu_pkg::ERR_TRUNC_U;
        jsu_pkg::MODE_AFTER_HI: begin
          cmd.fffd = 1'b1;
          cmd.err  = jsu_pkg::ERR_UNTERM_STR;
        end
        jsu_pkg::MODE_AFTER_HI_BS: begin
          cmd.fffd = 1'b1;
          cmd.err  = jsu_pkg::ERR_UNTERM_ESC;
        end
        default: cmd.err = jsu_pkg::ERR_UNTERM_STR;
      endcase
    end else begin
      case (mode_q)
        jsu_pkg::MODE_ESC: esc_en = 1'b1;
        jsu_pkg::MODE_HEX,
        jsu_pkg::MODE_LOW_HEX: begin
          if (!jsu_pkg::is_hex(byte_i)) begin
            cmd.term_en  = 1'b1;
            cmd.term_err = 1'b1;
            cmd.err      = jsu_pkg::ERR_BAD_HEX;
            mode_d       = jsu_pkg::MODE_NORMAL;
          end else if (cnt_q != 2'd3) begin
            cnt_d = cnt_q + 2'd1;
            acc_d = acc_n;
          end else begin
            cnt_d = 2'd0;
            acc_d = '0;
            if (mode_q == jsu_pkg::MODE_HEX) begin
              uni_en = 1'b1;
            end else if (acc_n >= 16'hDC00 && acc_n <= 16'hDFFF) begin
              enc     = jsu_pkg::utf8_encode(pair_cp);
              cmd.nb    = enc.nb;
              cmd.bytes = enc.bytes;
              mode_d    = jsu_pkg::MODE_NORMAL;
            end else begin
              // The pending high half had no partner.
              cmd.fffd = 1'b1;
              uni_en   = 1'b1;
            end
          end
        end
        jsu_pkg::MODE_AFTER_HI: begin
          if (byte_i == jsu_pkg::ChBackslash) begin
            mode_d = jsu_pkg::MODE_AFTER_HI_BS;
          end else begin
            cmd.fffd = 1'b1;
            body_en  = 1'b1;
          end
        end
        jsu_pkg::MODE_AFTER_HI_BS: begin
          if (byte_i == jsu_pkg::ChU) begin
            mode_d = jsu_pkg::MODE_LOW_HEX;
            cnt_d  = 2'd0;
            acc_d  = '0;
          end else begin
            cmd.fffd = 1'b1;
            esc_en   = 1'b1;
          end
        end
        default: body_en = 1'b1;
      endcase
    end

    if (body_en) begin
      mode_d = jsu_pkg::MODE_NORMAL;
      if (byte_i == jsu_pkg::ChQuote) begin
        cmd.term_en = 1'b1;
      end else if (byte_i < jsu_pkg::ChSpace) begin
        cmd.term_en  = 1'b1;
        cmd.term_err = 1'b1;
        cmd.err      = jsu_pkg::ERR_CTRL_CHAR;
      end else if (byte_i == jsu_pkg::ChBackslash) begin
        mode_d = jsu_pkg::MODE_ESC;
      end else begin
        cmd.nb       = 3'd1;
        cmd.bytes[0] = byte_i;
      end
    end

    if (esc_en) begin
      mode_d = jsu_pkg::MODE_NORMAL;
      if (esc.valid) begin
        cmd.nb       = 3'd1;
        cmd.bytes[0] = esc.value;
      end else if (byte_i == jsu_pkg::ChU) begin
        mode_d = jsu_pkg::MODE_HEX;
        cnt_d  = 2'd0;
        acc_d  = '0;
      end else begin
        cmd.term_en  = 1'b1;
        cmd.term_err = 1'b1;
        cmd.err      = jsu_pkg::ERR_UNKNOWN;
      end
    end

    if (uni_en) begin
      if (acc_n >= 16'hD800 && acc_n <= 16'hDBFF) begin
        pend_d = acc_n[9:0];
        mode_d = jsu_pkg::MODE_AFTER_HI;
      end else begin
        mode_d = jsu_pkg::MODE_NORMAL;
        if (acc_n >= 16'hDC00 && acc_n <= 16'hDFFF) begin
          cmd.fffd = 1'b1;
        end else begin
          enc       = jsu_pkg::utf8_encode({5'd0, acc_n});
          cmd.nb    = enc.nb;
          cmd.bytes = enc.bytes;
        end
      end
    end
  end

  assign cmd_o       = cmd;
  assign cmd_valid_o = accept_i && (cmd.fffd || (cmd.nb != 3'd0) || cmd.term_en);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= jsu_pkg::MODE_NORMAL;
      cnt_q  <= 2'd0;
      acc_q  <= '0;
      pend_q <= '0;
    end else if (accept_i) begin
      mode_q <= mode_d;
      cnt_q  <= cnt_d;
      acc_q  <= acc_d;
      pend_q <= pend_d;
    end
  end

endmodule

`default_nettype wire

FILE: design/jsu_queue.sv
// Two-entry command queue between the front end and the back end.
`timescale 1ns / 1ps
`default_nettype none

module jsu_queue (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire jsu_pkg::cmd_t push_cmd_i,
  input  wire logic          pop_i,
  output jsu_pkg::cmd_t      head_o,
  output jsu_pkg::q_stat_t   stat_o
);

  jsu_pkg::cmd_t entries_q [2];
  logic          wr_q, rd_q;
  logic [1:0]    cnt_q;

  assign head_o       = entries_q[rd_q];
  assign stat_o.valid = (cnt_q != 2'd0);
  assign stat_o.full  = (cnt_q == 2'd2);

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_q] <= push_cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) begin
        wr_q <= ~wr_q;
      end
      if (pop_i) begin
        rd_q <= ~rd_q;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

endmodule

`default_nettype wire

FILE: design/jsu_back.sv
// Back end: expands each command into result bytes, one per cycle unless stalled, into the output register.
`timescale 1ns / 1ps
`default_nettype none

module jsu_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire jsu_pkg::cmd_t head_i,
  input  wire logic          head_valid_i,
  output logic               pop_o,
  output logic               m_tvalid_o,
  input  wire logic          m_tready_i,
  output logic [15:0]        m_tdata_o,
  output logic [1:0]         m_tuser_o,
  output logic               m_tlast_o
);

  logic [2:0]     step_q, step_d;
  logic [2:0]     base;
  logic [2:0]     total;
  logic [2:0]     idx;
  logic           load;
  logic           is_last;
  logic [7:0]     res_byte;
  jsu_pkg::kind_e res_kind;
  jsu_pkg::err_e  res_err;

  logic           valid_q;
  logic [7:0]     byte_q;
  jsu_pkg::kind_e kind_q;
  jsu_pkg::err_e  err_q;
  logic           last_q;

  assign base    = head_i.fffd ? 3'd3 : 3'd0;
  assign total   = base + head_i.nb + {2'b00, head_i.term_en};
  assign idx     = step_q - base;
  assign is_last = (step_q == total - 3'd1);
  assign load    = head_valid_i && (!valid_q || m_tready_i);
  assign pop_o   = load && is_last;
  assign step_d  = pop_o ? 3'd0 : step_q + 3'd1;

  always_comb begin
    res_byte = 8'h00;
    res_kind = jsu_pkg::KIND_DATA;
    res_err  = jsu_pkg::ERR_UNTERM_STR;
    if (head_i.fffd && (step_q < 3'd3)) begin
      res_byte = jsu_pkg::FffdBytes[step_q[1:0]];
    end else if (idx < head_i.nb) begin
      res_byte = head_i.bytes[idx[1:0]];
    end else if (head_i.term_err) begin
      res_kind = jsu_pkg::KIND_ERR;
      res_err  = head_i.err;
    end else begin
      res_kind = jsu_pkg::KIND_DONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q  <= 3'd0;
      valid_q <= 1'b0;
    end else begin
      if (load) begin
        step_q <= step_d;
      end
      if (load) begin
        valid_q <= 1'b1;
      end else if (m_tready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q <= res_byte;
      kind_q <= res_kind;
      err_q  <= res_err;
      last_q <= is_last;
    end
  end

  assign m_tvalid_o = valid_q;
  assign m_tdata_o  = {5'd0, err_q, byte_q};
  assign m_tuser_o  = kind_q;
  assign m_tlast_o  = last_q;

endmodule

`default_nettype wire

FILE: design/json_string_unescape_utf8.sv
// Top level of the JSON string body decoder that produces UTF-8.
`timescale 1ns / 1ps
`default_nettype none

// Decodes the body of a JSON string, one byte per request, into UTF-8 result
// bytes, ending each string with a completion or an error result. A request is
// taken every cycle while the two-entry command queue has room. A plain byte
// gives one result via the queue and the output register, one per cycle while
// the output is ready. An escape can expand to up to six results (U+FFFD for a
// lone high surrogate followed by a three-byte character); the back end sends
// one result per cycle while not stalled, through its single output register,
// so such a request holds the output until its last result is sent, and the
// input stalls once the queue fills behind it. Requests that produce no result
// (a backslash, a hex digit before the fourth) only update the decoder state.
module json_string_unescape_utf8 (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] byte_in
  input  wire logic        s_axis_tuser,   // [0] end_of_input
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata,   // [7:0] out_byte, [10:8] error_code, rest zero
  output logic [1:0]       m_axis_tuser,   // [1:0] kind
  output logic             m_axis_tlast    // last
);

  jsu_pkg::cmd_t    cmd;
  jsu_pkg::cmd_t    head;
  jsu_pkg::q_stat_t q_stat;
  logic             accept;
  logic             cmd_valid;
  logic             pop;

  assign s_axis_tready = !q_stat.full;
  assign accept        = s_axis_tvalid && s_axis_tready;

  jsu_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .byte_i      (s_axis_tdata),
    .end_i       (s_axis_tuser),
    .cmd_o       (cmd),
    .cmd_valid_o (cmd_valid)
  );

  jsu_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (cmd_valid),
    .push_cmd_i (cmd),
    .pop_i      (pop),
    .head_o     (head),
    .stat_o     (q_stat)
  );

  jsu_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head),
    .head_valid_i (q_stat.valid),
    .pop_o        (pop),
    .m_tvalid_o   (m_axis_tvalid),
    .m_tready_i   (m_axis_tready),
    .m_tdata_o    (m_axis_tdata),
    .m_tuser_o    (m_axis_tuser),
    .m_tlast_o    (m_axis_tlast)
  );

  // Results that are not errors carry no error number.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser != jsu_pkg::KIND_ERR) |-> m_axis_tdata[10:8] == 3'd0)
    else $error("error code set on a non-error result");

  // A completion or an error is always the final result of its request.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser != jsu_pkg::KIND_DATA) |-> m_axis_tlast)
    else $error("terminal result without last");

  // The back end only retires a command that is present in the queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> q_stat.valid)
    else $error("queue popped while empty");

endmodule

`default_nettype wire

FILE: sim/testbench.sv
// Self-checking testbench for the JSON string body to UTF-8 decoder.
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned MaxResults  = 6;
  localparam int unsigned CycleLimit  = 250000;
  localparam int unsigned TotalItems  = 180;
  localparam int unsigned HoldAtItem  = 60;
  localparam int unsigned HoldCycles  = 300;

  typedef struct packed {
    logic [7:0] data;
    logic       eoi;
    logic       drain;
  } feed_t;

  typedef struct packed {
    logic [7:0]     data;
    jsu_pkg::kind_e kind;
    jsu_pkg::err_e  err;
    logic           last;
  } result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;   // [7:0] byte_in
  logic        s_axis_tuser;   // [0] end_of_input
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;   // [7:0] out_byte, [10:8] error_code, rest zero
  logic [1:0]  m_axis_tuser;   // [1:0] kind
  logic        m_axis_tlast;

  json_string_unescape_utf8 u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  feed_t       pending_q[$];
  result_t     expected_out_q[$];
  result_t     step_res[$];
  logic        drain_next = 1'b0;
  logic        in_fire = 1'b0;
  int unsigned items_in = 0;
  int unsigned mismatches = 0;
  int unsigned cycle_cnt = 0;
  int unsigned src_idle = 0;
  int unsigned sink_idle = 0;
  int unsigned hold_cnt = 0;
  logic        hold_done = 1'b0;
  feed_t       next_item;
  result_t     want;
  logic [7:0]  simple_letters [8];

  // Decoder state kept by the predictor.
  jsu_pkg::mode_e dec_mode;
  logic [1:0]     digit_cnt;
  logic [15:0]    code_acc;
  logic [15:0]    high_half;

  // No idling on either side while this window of requests goes through.
  function automatic logic calm();
    return (items_in >= 90) && (items_in < 130);
  endfunction

  function automatic int unsigned idle_len();
    int unsigned p;
    p = $urandom_range(99);
    if (p < 60) return 0;
    if (p < 92) return $urandom_range(3, 1);
    return $urandom_range(30, 8);
  endfunction

  // ---------------------------------------------------------------- predictor

  function automatic void clear_decoder();
    dec_mode  = jsu_pkg::MODE_NORMAL;
    digit_cnt = '0;
    code_acc  = '0;
    high_half = '0;
  endfunction

  // The error field reads zero unless the kind is an error.
  function automatic void put_res(input logic [7:0] b, input jsu_pkg::kind_e k,
                                  input jsu_pkg::err_e e);
    result_t r;
    r.data = (k == jsu_pkg::KIND_DATA) ? b : 8'h00;
    r.kind = k;
    r.err  = (k == jsu_pkg::KIND_ERR) ? e : jsu_pkg::ERR_UNTERM_STR;
    r.last = 1'b0;
    if (step_res.size() < MaxResults) step_res.insert(step_res.size(), r);
  endfunction

  function automatic void put_data(input logic [7:0] b);
    put_res(b, jsu_pkg::KIND_DATA, jsu_pkg::ERR_UNTERM_STR);
  endfunction

  function automatic void put_error(input jsu_pkg::err_e e);
    put_res(8'h00, jsu_pkg::KIND_ERR, e);
    clear_decoder();
  endfunction

  function automatic void put_code_point(input logic [20:0] cp);
    if (cp < 21'h80) begin
      put_data(cp[7:0]);
    end else if (cp < 21'h800) begin
      put_data({3'b110, cp[10:6]});
      put_data({2'b10, cp[5:0]});
    end else if (cp < 21'h10000) begin
      put_data({4'b1110, cp[15:12]});
      put_data({2'b10, cp[11:6]});
      put_data({2'b10, cp[5:0]});
    end else begin
      put_data({5'b11110, cp[20:18]});
      put_data({2'b10, cp[17:12]});
      put_data({2'b10, cp[11:6]});
      put_data({2'b10, cp[5:0]});
    end
  endfunction

  function automatic void put_replacement();
    put_code_point(21'hFFFD);
  endfunction

  // Bit 4 flags a valid hex digit, bits 3:0 hold its value.
  function automatic logic [4:0] hex_nibble(input logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return {1'b1, 4'(c - 8'h30)};
    if (c >= 8'h61 && c <= 8'h66) return {1'b1, 4'(c - 8'h57)};
    if (c >= 8'h41 && c <= 8'h46) return {1'b1, 4'(c - 8'h37)};
    return 5'b0;
  endfunction

  function automatic void body_byte(input logic [7:0] c);
    dec_mode = jsu_pkg::MODE_NORMAL;
    if (c == jsu_pkg::ChQuote) begin
      put_res(8'h00, jsu_pkg::KIND_DONE, jsu_pkg::ERR_UNTERM_STR);
      clear_decoder();
    end else if (c < jsu_pkg::ChSpace) begin
      put_error(jsu_pkg::ERR_CTRL_CHAR);
    end else if (c == jsu_pkg::ChBackslash) begin
      dec_mode = jsu_pkg::MODE_ESC;
    end else begin
      put_data(c);
    end
  endfunction

  function automatic void escape_byte(input logic [7:0] c);
    dec_mode = jsu_pkg::MODE_NORMAL;
    case (c)
      jsu_pkg::ChQuote:     put_data(jsu_pkg::ChQuote);
      jsu_pkg::ChBackslash: put_data(jsu_pkg::ChBackslash);
      8'h2F:                put_data(8'h2F);
      8'h62:                put_data(8'h08);
      8'h66:                put_data(8'h0C);
      8'h6E:                put_data(8'h0A);
      8'h72:                put_data(8'h0D);
      8'h74:                put_data(8'h09);
      jsu_pkg::ChU: begin
        dec_mode  = jsu_pkg::MODE_HEX;
        digit_cnt = '0;
        code_acc  = '0;
      end
      default:              put_error(jsu_pkg::ERR_UNKNOWN);
    endcase
  endfunction

  // A full \u value that does not complete a surrogate pair.
  function automatic void lone_value(input logic [15:0] v);
    digit_cnt = '0;
    code_acc  = '0;
    if (v >= 16'hD800 && v <= 16'hDBFF) begin
      high_half = v;
      dec_mode  = jsu_pkg::MODE_AFTER_HI;
    end else begin
      dec_mode = jsu_pkg::MODE_NORMAL;
      if (v >= 16'hDC00 && v <= 16'hDFFF) put_replacement();
      else put_code_point({5'b0, v});
    end
  endfunction

  function automatic void decode_byte(input logic [7:0] c, input logic eoi);
    jsu_pkg::mode_e m;
    logic [4:0]     nib;
    logic [15:0]    v;
    step_res.delete();
    m = dec_mode;
    if (eoi) begin
      case (m)
        jsu_pkg::MODE_ESC:      put_error(jsu_pkg::ERR_UNTERM_ESC);
        jsu_pkg::MODE_HEX,
        jsu_pkg::MODE_LOW_HEX:  put_error(jsu_pkg::ERR_TRUNC_U);
        jsu_pkg::MODE_AFTER_HI: begin
          put_replacement();
          put_error(jsu_pkg::ERR_UNTERM_STR);
        end
        jsu_pkg::MODE_AFTER_HI_BS: begin
          put_replacement();
          put_error(jsu_pkg::ERR_UNTERM_ESC);
        end
        default:                put_error(jsu_pkg::ERR_UNTERM_STR);
      endcase
    end else begin
      case (m)
        jsu_pkg::MODE_ESC: escape_byte(c);
        jsu_pkg::MODE_HEX, jsu_pkg::MODE_LOW_HEX: begin
          nib = hex_nibble(c);
          if (!nib[4]) begin
            put_error(jsu_pkg::ERR_BAD_HEX);
          end else begin
            code_acc = {code_acc[11:0], nib[3:0]};
            if (digit_cnt < 2'd3) begin
              digit_cnt = digit_cnt + 2'd1;
            end else begin
              v = code_acc;
              if (m == jsu_pkg::MODE_HEX) begin
                lone_value(v);
              end else if (v >= 16'hDC00 && v <= 16'hDFFF) begin
                // Pair offset lands directly in the low 20 bits above 0x10000.
                put_code_point(21'h10000 + {1'b0, high_half[9:0], v[9:0]});
                clear_decoder();
              end else begin
                put_replacement();
                high_half = '0;
                lone_value(v);
              end
            end
          end
        end
        jsu_pkg::MODE_AFTER_HI: begin
          if (c == jsu_pkg::ChBackslash) begin
            dec_mode = jsu_pkg::MODE_AFTER_HI_BS;
          end else begin
            put_replacement();
            high_half = '0;
            body_byte(c);
          end
        end
        jsu_pkg::MODE_AFTER_HI_BS: begin
          if (c == jsu_pkg::ChU) begin
            dec_mode  = jsu_pkg::MODE_LOW_HEX;
            digit_cnt = '0;
            code_acc  = '0;
          end else begin
            put_replacement();
            high_half = '0;
            escape_byte(c);
          end
        end
        default: body_byte(c);
      endcase
    end
    if (step_res.size() > 0) step_res[step_res.size() - 1].last = 1'b1;
    foreach (step_res[i]) expected_out_q.insert(expected_out_q.size(), step_res[i]);
  endfunction

  // ---------------------------------------------------------------- stimulus

  task automatic add_item(input logic [7:0] b, input logic eoi);
    feed_t f;
    f.data  = b;
    f.eoi   = eoi;
    f.drain = drain_next;
    drain_next = 1'b0;
    pending_q.insert(pending_q.size(), f);
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) add_item(s[i], 1'b0);
  endtask

  task automatic add_end();
    add_item(8'($urandom_range(255)), 1'b1);
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    if (n < 4'd10) return 8'h30 + {4'b0, n};
    return ($urandom_range(1) ? 8'h61 : 8'h41) + {4'b0, n} - 8'd10;
  endfunction

  task automatic add_digits(input int unsigned k);
    for (int unsigned i = 0; i < k; i++) add_item(hex_char(4'($urandom_range(15))), 1'b0);
  endtask

  task automatic add_u(input logic [15:0] v);
    add_item(jsu_pkg::ChBackslash, 1'b0);
    add_item(jsu_pkg::ChU, 1'b0);
    for (int i = 3; i >= 0; i--) add_item(hex_char(v[i*4 +: 4]), 1'b0);
  endtask

  function automatic logic [15:0] rand_high();
    if ($urandom_range(3) == 0) return $urandom_range(1) ? 16'hD800 : 16'hDBFF;
    return 16'($urandom_range(16'hDBFF, 16'hD800));
  endfunction

  function automatic logic [15:0] rand_low();
    if ($urandom_range(3) == 0) return $urandom_range(1) ? 16'hDC00 : 16'hDFFF;
    return 16'($urandom_range(16'hDFFF, 16'hDC00));
  endfunction

  function automatic logic [7:0] non_hex_byte();
    logic [7:0] b;
    b = 8'($urandom_range(255));
    if (hex_nibble(b) != 5'b0) b = 8'h67;
    return b;
  endfunction

  task automatic add_random_token();
    int unsigned pick;
    logic [7:0]  b;
    logic [15:0] v;
    pick = $urandom_range(99);
    if (pick < 40) begin
      b = 8'($urandom_range(255, 32));
      if (b == jsu_pkg::ChQuote || b == jsu_pkg::ChBackslash) b = 8'h7E;
      add_item(b, 1'b0);
    end else if (pick < 50) begin
      add_item(jsu_pkg::ChBackslash, 1'b0);
      add_item(simple_letters[$urandom_range(7)], 1'b0);
    end else if (pick < 58) begin
      case ($urandom_range(4))
        0:       v = 16'($urandom_range(16'h7F, 0));
        1:       v = 16'($urandom_range(16'h7FF, 16'h80));
        2:       v = 16'($urandom_range(16'hD7FF, 16'h800));
        3:       v = 16'($urandom_range(16'hFFFF, 16'hE000));
        default: v = $urandom_range(1) ? 16'hFFFF : 16'h0000;
      endcase
      add_u(v);
    end else if (pick < 65) begin
      add_u(rand_high());
      add_u(rand_low());
    end else if (pick < 68) begin
      // A lone high half; whatever token follows decides how it resolves.
      add_u(rand_high());
    end else if (pick < 70) begin
      add_u(rand_low());
    end else if (pick < 74) begin
      add_item(jsu_pkg::ChQuote, 1'b0);
    end else if (pick < 76) begin
      add_end();
    end else if (pick < 78) begin
      add_item(8'($urandom_range(31)), 1'b0);
    end else if (pick < 80) begin
      b = 8'($urandom_range(255));
      case (b)
        jsu_pkg::ChQuote, jsu_pkg::ChBackslash, jsu_pkg::ChU,
        8'h2F, 8'h62, 8'h66, 8'h6E, 8'h72, 8'h74: b = 8'h78;
        default: ;
      endcase
      add_item(jsu_pkg::ChBackslash, 1'b0);
      add_item(b, 1'b0);
    end else if (pick < 85) begin
      add_item(jsu_pkg::ChBackslash, 1'b0);
      add_item(jsu_pkg::ChU, 1'b0);
      add_digits($urandom_range(3));
      add_item(non_hex_byte(), 1'b0);
    end else if (pick < 88) begin
      if ($urandom_range(1)) add_u(rand_high());
      add_item(jsu_pkg::ChBackslash, 1'b0);
      add_item(jsu_pkg::ChU, 1'b0);
      add_digits($urandom_range(3));
      add_end();
    end else if (pick < 90) begin
      add_u(rand_high());
      case ($urandom_range(2))
        0:       add_u(rand_high());
        1:       add_u(16'($urandom_range(16'hD7FF, 0)));
        default: add_u(16'($urandom_range(16'hFFFF, 16'hE000)));
      endcase
    end else if (pick < 92) begin
      add_u(rand_high());
      add_item(jsu_pkg::ChBackslash, 1'b0);
      add_item(jsu_pkg::ChU, 1'b0);
      add_digits($urandom_range(3));
      add_item(non_hex_byte(), 1'b0);
    end else if (pick < 95) begin
      add_u(rand_high());
      if ($urandom_range(1)) add_item(jsu_pkg::ChBackslash, 1'b0);
      add_end();
    end else begin
      add_item(8'($urandom_range(255)), ($urandom_range(15) == 0));
    end
  endtask

  // ---------------------------------------------------------------- driving

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && !in_fire) begin
        // Request still waiting for the block.
      end else if (src_idle > 0) begin
        s_axis_tvalid <= 1'b0;
        src_idle = src_idle - 1;
      end else if (pending_q.size() > 0 &&
                   !(pending_q[0].drain && expected_out_q.size() > 0)) begin
        next_item = pending_q.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= next_item.data;
        s_axis_tuser  <= next_item.eoi;
        src_idle = calm() ? 0 : idle_len();
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Result side: one long hold-off once traffic is flowing, random stalls otherwise.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (hold_cnt > 0) begin
        hold_cnt = hold_cnt - 1;
        m_axis_tready <= 1'b0;
      end else if (!hold_done && items_in >= HoldAtItem) begin
        hold_done = 1'b1;
        hold_cnt  = HoldCycles;
        m_axis_tready <= 1'b0;
      end else if (sink_idle > 0) begin
        sink_idle = sink_idle - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        if (!calm() && $urandom_range(3) == 0) sink_idle = idle_len();
      end
    end
  end

  // ---------------------------------------------------------------- checking

  always @(posedge clk_i) begin
    cycle_cnt++;
    in_fire = rst_ni && s_axis_tvalid && s_axis_tready;
    if (in_fire) begin
      decode_byte(s_axis_tdata, s_axis_tuser);
      items_in++;
    end
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_out_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result with nothing expected: tdata %04h kind %0d last %0d",
                   $realtime, m_axis_tdata, m_axis_tuser, m_axis_tlast);
      end else begin
        want = expected_out_q.pop_front();
        if (m_axis_tdata[7:0] !== want.data || m_axis_tdata[10:8] !== want.err ||
            m_axis_tdata[15:11] !== 5'b0 || m_axis_tuser !== want.kind ||
            m_axis_tlast !== want.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"%0t: expected byte %02h err %0d kind %0d last %0d, ",
                      "got tdata %04h kind %0d last %0d"},
                     $realtime, want.data, want.err, want.kind, want.last,
                     m_axis_tdata, m_axis_tuser, m_axis_tlast);
        end
      end
    end
  end

  // ---------------------------------------------------------------- run control

  initial begin
    simple_letters = '{jsu_pkg::ChQuote, jsu_pkg::ChBackslash, 8'h2F, 8'h62, 8'h66,
                       8'h6E, 8'h72, 8'h74};
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = 8'h00;
    s_axis_tuser  = 1'b0;
    m_axis_tready = 1'b0;
    clear_decoder();

    // Directed opening: empty string, control and boundary bytes, escapes,
    // bad hex, and the text ending in the body, after a backslash and in hex.
    add_text("\"");
    add_item(8'h00, 1'b0);
    add_item(8'h1F, 1'b0);
    add_item(8'h20, 1'b0);
    add_item(8'hFF, 1'b0);
    add_text("\\q\\t\\u00g\\");
    add_end();
    add_text("A");
    add_end();
    add_text("\\uFF");
    add_end();

    // The sender waits for the block to drain before the random part and again at points inside it.
    drain_next = 1'b1;
    while (pending_q.size() < TotalItems) begin
      if (pending_q.size() >= 150 && pending_q.size() < 160 && !pending_q[$].drain &&
          !hold_done && $urandom_range(3) == 0)
        drain_next = 1'b1;
      add_random_token();
    end
    if (pending_q.size() > 150) pending_q[150].drain = 1'b1;

    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Sampled at the rising edge, where the driven inputs are settled.
    do begin
      @(posedge clk_i);
    end while (!(pending_q.size() == 0 && !s_axis_tvalid && expected_out_q.size() == 0));
    repeat (20) @(posedge clk_i);
    if (mismatches == 0 && expected_out_q.size() == 0) begin
      $display("json_string_unescape_utf8: match");
    end else begin
      $display("json_string_unescape_utf8: mismatch");
    end
    $finish;
  end

  initial begin
    wait (cycle_cnt >= CycleLimit);
    $display("json_string_unescape_utf8: mismatch");
    $finish;
  end

endmodule
